// ===== rtl/ckbb_pkg.sv =====
package ckbb_pkg;

  // Fixed field widths
  localparam int CFG_W    = 13;
  localparam int COORD_W  = 12;
  localparam int TINDEX_W = 15;
  localparam int CHAN_W   = 8;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  // Defaults for the top-level parameters, and the pixel queue depth
  localparam int MAX_DIM_DEF    = 4096;
  localparam int QUANT_BITS_DEF = 5;
  localparam int QUEUE_DEPTH    = 4;

  // Reset value of both frame dimension registers
  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(64);

  // Item kinds on the input channel
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_TABLE = 1'b1
  } kind_t;

  // Register indexes (byte address / 4)
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // Frame geometry handed to the front end
  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } frame_cfg_t;

endpackage

// ===== rtl/ckbb_front.sv =====
module ckbb_front import ckbb_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int QUANT_BITS = QUANT_BITS_DEF,
  parameter int ENTRY_W    = 2 * $clog2(MAX_DIM) + 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  frame_cfg_t         frame_cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [CHAN_W-1:0]  in_blue,
  input  logic [CHAN_W-1:0]  in_green,
  input  logic [CHAN_W-1:0]  in_red,
  input  logic [TINDEX_W-1:0] in_table_index,
  input  logic               in_table_bit,
  output logic               push_valid,
  input  logic               push_ready,
  output logic [ENTRY_W-1:0] push_data
);

  localparam int CW      = $clog2(MAX_DIM);
  localparam int DW      = CW + 1;
  localparam int EW      = (DW > CFG_W) ? DW : CFG_W;
  localparam int IW      = 3 * QUANT_BITS;
  localparam int ENTRIES = 1 << IW;

  logic          accept;
  logic          is_pixel;
  logic          is_table;
  logic [EW-1:0] w_ext;
  logic [EW-1:0] h_ext;
  logic [DW-1:0] width_c;
  logic [DW-1:0] height_c;
  logic [DW-1:0] col_inc;
  logic [DW-1:0] row_inc;
  logic          row_end;
  logic          frame_end;
  logic [CW-1:0] col_r;
  logic [CW-1:0] col_nxt;
  logic [CW-1:0] row_r;
  logic [CW-1:0] row_nxt;
  logic [IW-1:0] pix_idx;
  logic [IW-1:0] tbl_idx;
  logic          s1_valid_r;
  logic          s1_valid_nxt;
  logic [CW-1:0] s1_col_r;
  logic [CW-1:0] s1_row_r;
  logic          s1_last_r;
  logic          hit_r;

  // Color table, one bit per quantized color
  logic table_mem [0:ENTRIES-1];

  assign in_ready = !s1_valid_r || push_ready;
  assign accept   = in_valid && in_ready;
  assign is_pixel = (kind_t'(in_kind) == KIND_PIXEL);
  assign is_table = (kind_t'(in_kind) == KIND_TABLE);

  // Clamp frame dimensions: zero acts as one, saturate at MAX_DIM
  always_comb begin
    w_ext = EW'(frame_cfg.width);
    h_ext = EW'(frame_cfg.height);
    if (w_ext == '0) begin
      width_c = DW'(1);
    end else if (w_ext > EW'(MAX_DIM)) begin
      width_c = DW'(MAX_DIM);
    end else begin
      width_c = DW'(w_ext);
    end
    if (h_ext == '0) begin
      height_c = DW'(1);
    end else if (h_ext > EW'(MAX_DIM)) begin
      height_c = DW'(MAX_DIM);
    end else begin
      height_c = DW'(h_ext);
    end
  end

  // Raster position
  assign col_inc   = {1'b0, col_r} + DW'(1);
  assign row_inc   = {1'b0, row_r} + DW'(1);
  assign row_end   = (col_inc >= width_c);
  assign frame_end = row_end && (row_inc >= height_c);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept && is_pixel) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_inc[CW-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Table address: red:green:blue, top QUANT_BITS of each channel
  assign pix_idx = {in_red[CHAN_W-1 -: QUANT_BITS],
                    in_green[CHAN_W-1 -: QUANT_BITS],
                    in_blue[CHAN_W-1 -: QUANT_BITS]};
  assign tbl_idx = IW'(in_table_index);

  // One table access per transfer: a write or a registered read
  always_ff @(posedge clk) begin
    if (accept && is_table) begin
      table_mem[tbl_idx] <= in_table_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_pixel) begin
      hit_r <= table_mem[pix_idx];
    end
  end

  // Pixel stage that waits for queue space
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = is_pixel;
    end else if (push_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_pixel) begin
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_last_r <= frame_end;
    end
  end

  assign push_valid = s1_valid_r;
  assign push_data  = {s1_last_r, hit_r, s1_row_r, s1_col_r};

endmodule

// ===== rtl/ckbb_fifo.sv =====
module ckbb_fifo import ckbb_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             push;
  logic             pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = store_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue fill count above depth");

  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("queue count did not follow a lone push");

endmodule

// ===== rtl/ckbb_back.sv =====
module ckbb_back import ckbb_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int ENTRY_W = 2 * $clog2(MAX_DIM) + 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  logic [ENTRY_W-1:0] pop_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [COORD_W-1:0] out_col_min,
  output logic [COORD_W-1:0] out_col_max,
  output logic [COORD_W-1:0] out_row_min,
  output logic [COORD_W-1:0] out_row_max
);

  localparam int CW = $clog2(MAX_DIM);

  logic [CW-1:0] e_col;
  logic [CW-1:0] e_row;
  logic          e_hit;
  logic          e_last;
  logic          pop;
  logic [CW-1:0] col_min_r, col_min_nxt;
  logic [CW-1:0] col_max_r, col_max_nxt;
  logic [CW-1:0] row_min_r, row_min_nxt;
  logic [CW-1:0] row_max_r, row_max_nxt;
  logic          any_r, any_nxt;
  logic [CW-1:0] upd_col_min, upd_col_max, upd_row_min, upd_row_max;
  logic          upd_any;
  logic          out_valid_r, out_valid_nxt;
  logic          out_found_r;
  logic [COORD_W-1:0] out_col_min_r, out_col_max_r, out_row_min_r, out_row_max_r;

  assign {e_last, e_hit, e_row, e_col} = pop_data;

  // A frame end waits while the result register is still full
  assign pop_ready = !e_last || !out_valid_r || out_ready;
  assign pop       = pop_valid && pop_ready;

  // Box widened by the current pixel
  always_comb begin
    upd_col_min = col_min_r;
    upd_col_max = col_max_r;
    upd_row_min = row_min_r;
    upd_row_max = row_max_r;
    upd_any     = any_r;
    if (e_hit) begin
      if (e_col < col_min_r) upd_col_min = e_col;
      if (e_col > col_max_r) upd_col_max = e_col;
      if (e_row < row_min_r) upd_row_min = e_row;
      if (e_row > row_max_r) upd_row_max = e_row;
      upd_any = 1'b1;
    end
  end

  // Box state: widen per popped pixel, clear after frame end
  always_comb begin
    col_min_nxt = col_min_r;
    col_max_nxt = col_max_r;
    row_min_nxt = row_min_r;
    row_max_nxt = row_max_r;
    any_nxt     = any_r;
    if (pop) begin
      if (e_last) begin
        col_min_nxt = '1;
        col_max_nxt = '0;
        row_min_nxt = '1;
        row_max_nxt = '0;
        any_nxt     = 1'b0;
      end else begin
        col_min_nxt = upd_col_min;
        col_max_nxt = upd_col_max;
        row_min_nxt = upd_row_min;
        row_max_nxt = upd_row_max;
        any_nxt     = upd_any;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_min_r <= '1;
      col_max_r <= '0;
      row_min_r <= '1;
      row_max_r <= '0;
      any_r     <= 1'b0;
    end else begin
      col_min_r <= col_min_nxt;
      col_max_r <= col_max_nxt;
      row_min_r <= row_min_nxt;
      row_max_r <= row_max_nxt;
      any_r     <= any_nxt;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && e_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Empty box reads as zero
  always_ff @(posedge clk) begin
    if (pop && e_last) begin
      out_found_r   <= upd_any;
      out_col_min_r <= upd_any ? COORD_W'(upd_col_min) : '0;
      out_col_max_r <= upd_any ? COORD_W'(upd_col_max) : '0;
      out_row_min_r <= upd_any ? COORD_W'(upd_row_min) : '0;
      out_row_max_r <= upd_any ? COORD_W'(upd_row_max) : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_found   = out_found_r;
  assign out_col_min = out_col_min_r;
  assign out_col_max = out_col_max_r;
  assign out_row_min = out_row_min_r;
  assign out_row_max = out_row_max_r;

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_col_min_r == '0 && out_col_max_r == '0
      && out_row_min_r == '0 && out_row_max_r == '0)
    else $error("empty result carries a nonzero box");

  a_frame_hit: assert property (@(posedge clk) disable iff (!rst_n)
    pop && e_last && e_hit |=> out_valid_r && out_found_r)
    else $error("hit on last pixel not reported");

endmodule

// ===== rtl/color_key_bounding_box.sv =====
// The last pixel reaches out_valid via the pixel stage, queue and result register.
// Throughput: one item (pixel or table write) per cycle, set by the single-port
//   color table, one read or one write per transfer; a full queue can stall it.
// Reset (rst_n, synchronous): raster position and box cleared, frame size 64 x 64.
//   The color table is not cleared; entries are undefined until written.
module color_key_bounding_box import ckbb_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int QUANT_BITS = QUANT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic [CHAN_W-1:0]   in_blue,
  input  logic [CHAN_W-1:0]   in_green,
  input  logic [CHAN_W-1:0]   in_red,
  input  logic [TINDEX_W-1:0] in_table_index,
  input  logic                in_table_bit,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_found,
  output logic [COORD_W-1:0]  out_col_min,
  output logic [COORD_W-1:0]  out_col_max,
  output logic [COORD_W-1:0]  out_row_min,
  output logic [COORD_W-1:0]  out_row_max
);

  localparam int ENTRY_W = 2 * $clog2(MAX_DIM) + 2;

  logic [CFG_W-1:0]   width_r;
  logic [CFG_W-1:0]   height_r;
  logic               cfg_wr;
  reg_idx_t           reg_sel;
  frame_cfg_t         frame_cfg;
  logic               q_push_valid;
  logic               q_push_ready;
  logic [ENTRY_W-1:0] q_push_data;
  logic               q_pop_valid;
  logic               q_pop_ready;
  logic [ENTRY_W-1:0] q_pop_data;

  // Register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_FRAME_WIDTH:  width_r  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: height_r <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FRAME_WIDTH:  prdata = DATA_W'(width_r);
      REG_FRAME_HEIGHT: prdata = DATA_W'(height_r);
    endcase
  end

  assign frame_cfg.width  = width_r;
  assign frame_cfg.height = height_r;

  // Front: table access and raster tracking
  ckbb_front #(
    .MAX_DIM    (MAX_DIM),
    .QUANT_BITS (QUANT_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .frame_cfg      (frame_cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_blue        (in_blue),
    .in_green       (in_green),
    .in_red         (in_red),
    .in_table_index (in_table_index),
    .in_table_bit   (in_table_bit),
    .push_valid     (q_push_valid),
    .push_ready     (q_push_ready),
    .push_data      (q_push_data)
  );

  // Pixel queue between front and back
  ckbb_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  // Back: box accumulation and result register
  ckbb_back #(
    .MAX_DIM (MAX_DIM),
    .ENTRY_W (ENTRY_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (q_pop_valid),
    .pop_ready   (q_pop_ready),
    .pop_data    (q_pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_found   (out_found),
    .out_col_min (out_col_min),
    .out_col_max (out_col_max),
    .out_row_min (out_row_min),
    .out_row_max (out_row_max)
  );

endmodule
